/* sv/ilha_pkg.sv */
// ilha_pkg: shared types and constants for the implicit-list heap allocator.
// Depends on nothing; used by ilha_walker and implicit_list_heap_allocator.
package ilha_pkg;

    // request and result field widths
    localparam int REQ_BYTES_W = 15;
    localparam int BLK_ADDR_W  = 12;
    localparam int UNITS_W     = 13;   // rounded-up request in units, up to 4096
    localparam int UNIT_SHIFT  = 3;    // 8-byte units

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CHK,
        S_A_EVAL,
        S_A_APPEND,
        S_A_HDR,
        S_F_HDR,
        S_F_CHK,
        S_F_EVAL,
        S_F_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                   req_type;
        logic [REQ_BYTES_W-1:0] req_bytes;
        logic [BLK_ADDR_W-1:0]  block_addr;
    } t_req;

    typedef struct packed {
        logic                  valid;
        logic [BLK_ADDR_W-1:0] payload_addr;
        logic                  ok;
    } t_res;

endpackage

/* sv/ilha_ram.sv */
// ilha_ram: generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ilha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ilha_walker.sv */
// ilha_walker: header-walk sequencer for allocate and free, with the header RAM.
// Depends on ilha_pkg and ilha_ram.
module ilha_walker #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ilha_pkg::t_req i_req,
    input  logic          i_take,
    output logic          o_busy,
    output ilha_pkg::t_res o_res
);

    localparam int AW = $clog2(HEAP_UNITS);   // header index
    localparam int SW = AW + 1;               // block size, up to HEAP_UNITS
    localparam int DW = SW + 1;               // used bit on top of size
    localparam int PW = AW + 2;               // walk pointer, may pass the heap end
    localparam int CW = (AW + 2 > ilha_pkg::UNITS_W + 2) ? AW + 2 : ilha_pkg::UNITS_W + 2;
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_UNITS);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    ilha_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_p, n_p;
    logic [ilha_pkg::UNITS_W-1:0] r_n, n_n;
    logic [SW-1:0] r_top, n_top;
    logic [PW-1:0] r_sz, n_sz;
    logic [AW-1:0] r_h, n_h;
    logic [ilha_pkg::BLK_ADDR_W-1:0] r_res_addr, n_res_addr;
    logic r_res_ok, n_res_ok;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    ilha_ram #(
        .WIDTH (DW),
        .DEPTH (HEAP_UNITS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // header fields read back from RAM, widened for compares
    logic          rd_used;
    logic [CW-1:0] rd_size, p_c, n_c, top_c, sz_c;
    logic [CW-1:0] units_c, free_h_c, split_pos, adv_p, sz_sum;

    always_comb begin
        rd_used   = ram_rdata[DW-1];
        rd_size   = CW'(ram_rdata[SW-1:0]);
        p_c       = CW'(r_p);
        n_c       = CW'(r_n);
        top_c     = CW'(r_top);
        sz_c      = CW'(r_sz);
        units_c   = CW'((CW'(i_req.req_bytes) + CW'(7)) >> ilha_pkg::UNIT_SHIFT);
        free_h_c  = CW'(i_req.block_addr) - ONE_C;
        split_pos = p_c + n_c + ONE_C;
        adv_p     = p_c + rd_size + ONE_C;
        sz_sum    = sz_c + rd_size + ONE_C;
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ilha_pkg::S_IDLE;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
        end
        r_p        <= n_p;
        r_n        <= n_n;
        r_sz       <= n_sz;
        r_h        <= n_h;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
    end

    // sequencer: one header read per check-and-evaluate state pair, RAM writes at the end
    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_n        = r_n;
        n_top      = r_top;
        n_sz       = r_sz;
        n_h        = r_h;
        n_res_addr = r_res_addr;
        n_res_ok   = r_res_ok;
        ram_we     = 1'b0;
        ram_waddr  = r_p[AW-1:0];
        ram_wdata  = '0;
        ram_raddr  = r_p[AW-1:0];

        unique case (r_state)
            ilha_pkg::S_IDLE: begin
                if (i_start) begin
                    n_n = units_c[ilha_pkg::UNITS_W-1:0];
                    n_p = '0;
                    if (i_req.req_type == ilha_pkg::REQ_ALLOC) begin
                        n_state = ilha_pkg::S_A_CHK;
                    end else if (i_req.block_addr == '0 || free_h_c >= top_c) begin
                        // bad free: rejected, state untouched
                        n_res_addr = '0;
                        n_res_ok   = 1'b0;
                        n_state    = ilha_pkg::S_DONE;
                    end else begin
                        n_h       = free_h_c[AW-1:0];
                        ram_raddr = free_h_c[AW-1:0];
                        n_state   = ilha_pkg::S_F_HDR;
                    end
                end
            end

            ilha_pkg::S_A_CHK: begin
                if (p_c < top_c) begin
                    n_state = ilha_pkg::S_A_EVAL;
                end else begin
                    n_state = ilha_pkg::S_A_APPEND;
                end
            end

            ilha_pkg::S_A_EVAL: begin
                if (!rd_used && rd_size > n_c + ONE_C && split_pos < HEAP_C) begin
                    // split: free remainder header after the taken block
                    ram_we    = 1'b1;
                    ram_waddr = split_pos[AW-1:0];
                    ram_wdata = {1'b0, SW'(rd_size - n_c - ONE_C)};
                    n_state   = ilha_pkg::S_A_HDR;
                end else if (!rd_used && rd_size == n_c) begin
                    n_state = ilha_pkg::S_A_HDR;
                end else begin
                    n_p     = adv_p[PW-1:0];
                    n_state = ilha_pkg::S_A_CHK;
                end
            end

            ilha_pkg::S_A_APPEND: begin
                if (top_c + n_c + ONE_C > HEAP_C || top_c + ONE_C >= HEAP_C) begin
                    n_res_addr = '0;
                    n_res_ok   = 1'b0;
                    n_state    = ilha_pkg::S_DONE;
                end else begin
                    n_top   = SW'(top_c + n_c + ONE_C);
                    n_p     = PW'(r_top);
                    n_state = ilha_pkg::S_A_HDR;
                end
            end

            ilha_pkg::S_A_HDR: begin
                ram_we     = 1'b1;
                ram_wdata  = {1'b1, SW'(n_c)};
                n_res_addr = ilha_pkg::BLK_ADDR_W'(p_c + ONE_C);
                n_res_ok   = 1'b1;
                n_state    = ilha_pkg::S_DONE;
            end

            ilha_pkg::S_F_HDR: begin
                n_sz    = PW'(rd_size);
                n_p     = PW'(CW'(r_h) + rd_size + ONE_C);
                n_state = ilha_pkg::S_F_CHK;
            end

            ilha_pkg::S_F_CHK: begin
                if (p_c < top_c) begin
                    n_state = ilha_pkg::S_F_EVAL;
                end else begin
                    n_state = ilha_pkg::S_F_WR;
                end
            end

            ilha_pkg::S_F_EVAL: begin
                if (!rd_used) begin
                    // absorb the following free block, size saturates at heap size
                    n_sz    = (sz_sum > HEAP_C) ? PW'(HEAP_C) : PW'(sz_sum);
                    n_p     = adv_p[PW-1:0];
                    n_state = ilha_pkg::S_F_CHK;
                end else begin
                    n_state = ilha_pkg::S_F_WR;
                end
            end

            ilha_pkg::S_F_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_h;
                ram_wdata  = {1'b0, SW'(r_sz)};
                n_res_addr = '0;
                n_res_ok   = 1'b1;
                n_state    = ilha_pkg::S_DONE;
            end

            ilha_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = ilha_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ilha_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy             = (r_state != ilha_pkg::S_IDLE);
    assign o_res.valid        = (r_state == ilha_pkg::S_DONE);
    assign o_res.payload_addr = r_res_addr;
    assign o_res.ok           = r_res_ok;

endmodule

/* sv/implicit_list_heap_allocator.sv */
// implicit_list_heap_allocator: first-fit allocator top level. Depends on ilha_pkg, ilha_walker.
// Allocate walks the headers first-fit from unit 0 and appends at the heap top when none fits;
// free absorbs the free blocks that follow until a block in use or the heap top; a bad free
// skips the walk. One item per walk; a new item is taken while a result waits in the output
// register.
// Synchronous reset empties the heap (top = 0); header RAM contents are not cleared.
module implicit_list_heap_allocator #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [14:0] i_req_bytes,
    input  logic [11:0] i_block_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_payload_addr,
    output logic        o_ok
);

    ilha_pkg::t_req req;
    ilha_pkg::t_res res;
    logic busy, start, take;
    logic r_out_valid;
    logic [11:0] r_out_addr;
    logic r_out_ok;

    assign req.req_type   = i_req_type;
    assign req.req_bytes  = i_req_bytes;
    assign req.block_addr = i_block_addr;
    assign start          = i_valid && !busy;
    assign take           = !r_out_valid || !i_stall;

    ilha_walker #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .i_take  (take),
        .o_busy  (busy),
        .o_res   (res)
    );

    // output register: holds a result item until downstream takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
        if (take && res.valid) begin
            r_out_addr <= res.payload_addr;
            r_out_ok   <= res.ok;
        end
    end

    assign o_stall        = busy;
    assign o_valid        = r_out_valid;
    assign o_payload_addr = r_out_addr;
    assign o_ok           = r_out_ok;

endmodule

/* sv/ilha_checker.sv */
// ilha_checker: port-level assertions for implicit_list_heap_allocator, with bind.
// Depends on implicit_list_heap_allocator port names only.
module ilha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_payload_addr,
    input logic        o_ok
);

    // a failed result never carries an address
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_payload_addr == 12'd0))
        else $error("failed result with nonzero address");

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting an item");

    // reset leaves no result item pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result stays and does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_payload_addr) && $stable(o_ok)))
        else $error("stalled result item changed");

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_payload_addr (o_payload_addr),
    .o_ok           (o_ok)
);

/* tb/heap_alloc_checker.sv */
`timescale 1ns / 100ps
// heap_alloc_checker: watches both channels of implicit_list_heap_allocator, predicts
// each result from a shadow copy of the header store and heap top, and counts mismatches.
// Depends on ilha_pkg.
module heap_alloc_checker #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_stall,
    input  logic                            i_req_type,
    input  logic [ilha_pkg::REQ_BYTES_W-1:0] i_req_bytes,
    input  logic [ilha_pkg::BLK_ADDR_W-1:0] i_block_addr,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [ilha_pkg::BLK_ADDR_W-1:0] o_payload_addr,
    input  logic                            o_ok,
    output int                              o_fail_count
);

    typedef struct {
        logic [ilha_pkg::BLK_ADDR_W-1:0] payload_addr;
        logic                            ok;
    } t_heap_reply;

    // shadow heap: one header per unit
    logic [ilha_pkg::UNITS_W-1:0] hdr_size    [HEAP_UNITS];
    bit                           hdr_used    [HEAP_UNITS];
    bit                           hdr_written [HEAP_UNITS];
    int unsigned                  heap_top_units = 0;

    // payload addresses of blocks in use, and of every header ever written
    int unsigned live_blocks[$];
    int unsigned known_headers[$];

    t_heap_reply pending_results[$];
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic void write_header(input int unsigned idx, input int unsigned units,
                                         input bit in_use);
        hdr_size[idx] = ilha_pkg::UNITS_W'(units);
        hdr_used[idx] = in_use;
        if (!hdr_written[idx]) begin
            hdr_written[idx] = 1'b1;
            if (idx + 1 < HEAP_UNITS) known_headers.push_back(idx + 1);
        end
    endfunction

    // First-fit walk from unit 0: exact size, or big enough to leave a remainder block.
    function automatic bit find_fit(input int unsigned units, output int unsigned at,
                                    output bit split);
        int unsigned s;
        at    = 0;
        split = 1'b0;
        while (at < heap_top_units) begin
            s = hdr_size[at];
            if (!hdr_used[at]) begin
                if (s > units + 1 && at + units + 1 < HEAP_UNITS) begin
                    split = 1'b1;
                    return 1'b1;
                end
                if (s == units) return 1'b1;
            end
            at += s + 1;
        end
        return 1'b0;
    endfunction

    function automatic t_heap_reply alloc_result(
        input logic [ilha_pkg::REQ_BYTES_W-1:0] req_bytes);
        t_heap_reply r;
        int unsigned units, at;
        bit          split;
        units          = (32'(req_bytes) + 7) >> ilha_pkg::UNIT_SHIFT;
        r.payload_addr = '0;
        r.ok           = 1'b0;
        if (find_fit(units, at, split)) begin
            if (split) write_header(at + units + 1, hdr_size[at] - units - 1, 1'b0);
        end else begin
            // bump the heap top, unless the block would not fit
            at = heap_top_units;
            if (at + units + 1 > HEAP_UNITS || at + 1 >= HEAP_UNITS) return r;
            heap_top_units = at + units + 1;
        end
        write_header(at, units, 1'b1);
        r.payload_addr = ilha_pkg::BLK_ADDR_W'(at + 1);
        r.ok           = 1'b1;
        if (at + 1 < HEAP_UNITS) live_blocks.push_back(at + 1);
        return r;
    endfunction

    function automatic t_heap_reply free_result(
        input logic [ilha_pkg::BLK_ADDR_W-1:0] block_addr);
        t_heap_reply r;
        int unsigned a, hdr, nxt, s, merged;
        int          found_at[$];
        a              = block_addr;
        r.payload_addr = '0;
        r.ok           = 1'b0;
        if (a == 0 || a - 1 >= heap_top_units) return r;
        hdr           = a - 1;
        hdr_used[hdr] = 1'b0;
        merged        = hdr_size[hdr];
        nxt           = hdr + merged + 1;
        // absorb the free blocks that follow, stopping at a block in use or the heap top
        while (nxt < heap_top_units && !hdr_used[nxt]) begin
            s      = hdr_size[nxt];
            merged += s + 1;
            if (merged > HEAP_UNITS) merged = HEAP_UNITS;
            nxt    += s + 1;
        end
        hdr_size[hdr] = ilha_pkg::UNITS_W'(merged);
        found_at = live_blocks.find_first_index(x) with (x == a);
        if (found_at.size() != 0) live_blocks.delete(found_at[0]);
        r.ok = 1'b1;
        return r;
    endfunction

    // compare results first, then predict the item taken at this edge
    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            heap_top_units = 0;
            pending_results.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: payload_addr %0d ok %0b", o_payload_addr, o_ok);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_payload_addr !== want.payload_addr) begin
                        $error("payload_addr: expected %0d, got %0d",
                               want.payload_addr, o_payload_addr);
                        mismatch_count++;
                    end
                    if (o_ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, o_ok);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (i_req_type == ilha_pkg::REQ_ALLOC) begin
                    pending_results.push_back(alloc_result(i_req_bytes));
                end else begin
                    pending_results.push_back(free_result(i_block_addr));
                end
            end
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: drives allocate and free items into implicit_list_heap_allocator with random
// idling on both sides; checking is done by heap_alloc_checker. Depends on ilha_pkg.
module tb_top;

    localparam int HEAP_UNITS   = 4096;
    localparam int RANDOM_ITEMS = 110;
    localparam int QUIET_ITEMS  = 20;
    localparam int CLOSE_TRIES  = 40;
    localparam int SETTLE_CYCLES = 20;
    // worst case: ~175 items, each a full-heap walk plus stall and gap bursts, times 3
    localparam int CYCLE_LIMIT  = 6_000_000;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_valid      = 1'b0;
    logic                             i_req_type   = ilha_pkg::REQ_ALLOC;
    logic [ilha_pkg::REQ_BYTES_W-1:0] i_req_bytes  = '0;
    logic [ilha_pkg::BLK_ADDR_W-1:0]  i_block_addr = '0;
    logic                             i_stall      = 1'b0;
    logic                             o_stall;
    logic                             o_valid;
    logic [ilha_pkg::BLK_ADDR_W-1:0]  o_payload_addr;
    logic                             o_ok;

    int fail_count;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;
    bit calm        = 1'b0;

    implicit_list_heap_allocator #(.HEAP_UNITS(HEAP_UNITS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_req_bytes    (i_req_bytes),
        .i_block_addr   (i_block_addr),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_addr (o_payload_addr),
        .o_ok           (o_ok)
    );

    heap_alloc_checker #(.HEAP_UNITS(HEAP_UNITS)) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_req_bytes    (i_req_bytes),
        .i_block_addr   (i_block_addr),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_addr (o_payload_addr),
        .o_ok           (o_ok),
        .o_fail_count   (fail_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result-side stall bursts at random; calm stretches have none
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm <= !calm;
        if (quiet) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // present one item, optionally after an idle burst, and hold it until taken
    task automatic send_item(input logic req_type,
                             input logic [ilha_pkg::REQ_BYTES_W-1:0] req_bytes,
                             input logic [ilha_pkg::BLK_ADDR_W-1:0] block_addr);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req_type;
        i_req_bytes  <= req_bytes;
        i_block_addr <= block_addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // the unused field carries random bits
    task automatic alloc_req(input logic [ilha_pkg::REQ_BYTES_W-1:0] req_bytes);
        send_item(ilha_pkg::REQ_ALLOC, req_bytes,
                  ilha_pkg::BLK_ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
    endtask

    task automatic free_req(input logic [ilha_pkg::BLK_ADDR_W-1:0] block_addr);
        send_item(ilha_pkg::REQ_FREE, ilha_pkg::REQ_BYTES_W'($urandom_range(0, 32760)),
                  block_addr);
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_all_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (chk.pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned top_now, fit_at, pick, sel, i, k;
        bit          fit_split, heap_full;
        logic [ilha_pkg::REQ_BYTES_W-1:0] nbytes;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // appends with byte counts that round up to whole units
        alloc_req(15'd0);
        alloc_req(15'd1);
        alloc_req(15'd8);
        alloc_req(15'd9);
        alloc_req(15'd40);
        alloc_req(15'd16);
        // rejected frees: address zero, far past the top, header right at the top
        free_req(12'd0);
        free_req(12'd4095);
        free_req(12'd18);
        // free, then split it, then take the remainder by exact fit
        free_req(12'd9);
        alloc_req(15'd16);
        alloc_req(15'd16);
        // free two neighbors so the first absorbs the second
        free_req(12'd12);
        free_req(12'd9);
        alloc_req(15'd24);
        alloc_req(15'd8);
        // a free block one unit too big neither fits nor splits
        free_req(12'd6);
        alloc_req(15'd8);
        // merge runs up to the heap top and stops there
        free_req(12'd18);
        free_req(12'd15);
        // largest request cannot be appended
        alloc_req(15'd32760);
        alloc_req(15'd32);
        // zero-size block freed and reused
        free_req(12'd1);
        alloc_req(15'd0);
        wait_all_results();

        // mostly live-block traffic, some stale, doubled and out-of-range frees
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50 || chk.live_blocks.size() == 0) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) nbytes = 15'($urandom_range(0, 200));
                else if (sel < 92) nbytes = 15'($urandom_range(0, 1023));
                else if (sel < 98) nbytes = 15'($urandom_range(0, 16383));
                else nbytes = 15'($urandom_range(16384, 32760));
                alloc_req(nbytes);
            end else if (pick < 85) begin
                free_req(12'(chk.live_blocks[$urandom_range(0, chk.live_blocks.size() - 1)]));
            end else if (pick < 90) begin
                free_req(12'd0);
            end else if (pick < 95) begin
                free_req(12'(chk.known_headers[$urandom_range(0, chk.known_headers.size() - 1)]));
            end else begin
                // an address past the top is only safe once the heap has settled
                wait_all_results();
                top_now = chk.heap_top_units;
                if (top_now + 1 < HEAP_UNITS) begin
                    free_req(12'($urandom_range(top_now + 1, HEAP_UNITS - 1)));
                end else begin
                    free_req(12'd0);
                end
            end
        end

        // fill the heap up to its last unit, then ask for a zero-size block there
        quiet     = 1'b1;
        heap_full = 1'b0;
        for (k = 0; k < CLOSE_TRIES && !heap_full; k++) begin
            wait_all_results();
            top_now = chk.heap_top_units;
            if (top_now + 1 < HEAP_UNITS) begin
                alloc_req(15'((HEAP_UNITS - 2 - top_now) * 8));
            end else if (top_now + 1 == HEAP_UNITS && chk.find_fit(0, fit_at, fit_split)) begin
                // use up the free block a zero-size request would take
                alloc_req(15'(chk.hdr_size[fit_at] * 8));
            end else begin
                alloc_req(15'd0);
                heap_full = 1'b1;
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
